/* rtl/core/modular_inverse_ext_euclid_unit_defines.svh */
// Assertion macros for the modular inverse unit.
`ifndef MODULAR_INVERSE_EXT_EUCLID_UNIT_DEFINES_SVH
`define MODULAR_INVERSE_EXT_EUCLID_UNIT_DEFINES_SVH
`ifndef SYNTH
`define MI_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MI_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MI_ASSERT(label, clk, rst, prop, msg)
`define MI_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

/* rtl/core/mie_pkg.sv */
// ----------------------------------------------------------------------------
// mie_pkg
// Shared types for the modular inverse unit.
// ----------------------------------------------------------------------------
package mie_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_REDUCE,
    ST_DIV,
    ST_UPDATE,
    ST_FIX,
    ST_DONE
  } mie_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture operands
    logic div_start; // start a division r0 / r1 (or v / m when reduce)
    logic reduce;    // division is the initial v mod m
    logic reduce_wr; // write reduction result into r1
    logic update;    // one Euclid round
    logic fix;       // final correction
  } mie_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_busy;
    logic r1_zero;
    logic bad_mod;
  } mie_sts_t;

endpackage

/* rtl/core/mie_if.sv */
// ----------------------------------------------------------------------------
// mie_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface mie_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/modular_inverse_ext_euclid_unit.sv */
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid_unit
// Modular inverse by the extended Euclidean algorithm.
// ----------------------------------------------------------------------------
// One item at a time. An item takes one reduction division and one division
// per Euclid round on the single shared bit-serial divider, plus the load,
// fix and done states. The result holds until taken; a new item is accepted
// once it is. Modulus is register 0 at byte address 0 (64-bit data),
// saturated to 2^WIDTH; a modulus below two yields no_inverse for every value.
module modular_inverse_ext_euclid_unit
  import mie_pkg::*;
#(
  parameter int WIDTH = 40
) (
  input  logic        clk,
  input  logic        rst,
  mie_if.sink         in_ch,
  mie_if.source       out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  logic [WIDTH:0] modulus;
  mie_cmd_t cmd;
  mie_sts_t sts;
  logic [WIDTH-1:0] inverse;
  logic no_inverse;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) modulus <= {1'b1, {WIDTH{1'b0}}};
    else if (psel && penable && pwrite && paddr == 1'b0) modulus <= pwdata[WIDTH:0];
  end
  assign prdata = (paddr == 1'b0) ? 64'(modulus) : '0;

  mie_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  mie_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .value(in_ch.data[WIDTH-1:0]), .modulus(modulus),
    .sts(sts), .inverse(inverse), .no_inverse(no_inverse)
  );

  assign out_ch.data = {inverse, no_inverse};
endmodule

/* rtl/core/mie_div.sv */
// ----------------------------------------------------------------------------
// mie_div
// Restoring divider, one quotient bit a cycle, with quotient * mcand
// built alongside by shift and add.
// ----------------------------------------------------------------------------
module mie_div #(
  parameter int W  = 41,
  parameter int PW = 42
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [W-1:0]         dividend,
  input  logic [W-1:0]         divisor,
  input  logic signed [PW-1:0] mcand,   // held steady while busy
  output logic                 busy,
  output logic [W-1:0]         rem,
  output logic signed [PW-1:0] prod
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]         q;
  logic [W:0]           r;
  logic [W-1:0]         d;
  logic [CW-1:0]        cnt;
  logic [W:0]           trial;
  logic [W:0]           shifted;
  logic signed [PW-1:0] p;
  logic signed [PW-1:0] p_add;

  assign shifted = {r[W-1:0], q[W-1]};
  assign trial   = shifted - {1'b0, d};
  // quotient bits arrive MSB first; each partial product is a prefix of q
  // times mcand, so it never exceeds the final product in magnitude
  assign p_add   = trial[W] ? '0 : mcand;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(W);
      q    <= dividend;
      r    <= '0;
      d    <= divisor;
      p    <= '0;
    end else if (busy) begin
      if (trial[W]) begin
        r <= shifted;
        q <= {q[W-2:0], 1'b0};
      end else begin
        r <= trial;
        q <= {q[W-2:0], 1'b1};
      end
      p   <= (p <<< 1) + p_add;
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  assign rem  = r[W-1:0];
  assign prod = p;
endmodule

/* rtl/core/mie_datapath.sv */
// ----------------------------------------------------------------------------
// mie_datapath
// Remainder and coefficient registers, divider and round update.
// ----------------------------------------------------------------------------
module mie_datapath
  import mie_pkg::*;
#(
  parameter int WIDTH = 40
) (
  input  logic             clk,
  input  logic             rst,
  input  mie_cmd_t         cmd,
  input  logic [WIDTH-1:0] value,
  input  logic [WIDTH:0]   modulus,
  output mie_sts_t         sts,
  output logic [WIDTH-1:0] inverse,
  output logic             no_inverse
);
  localparam int MW = WIDTH + 1;
  localparam int TW = WIDTH + 2;

  logic [MW-1:0] m, r0, r1, v;
  logic signed [TW-1:0] t0, t1;
  logic [MW-1:0] rem;
  logic [MW-1:0] m_sat;
  logic signed [TW-1:0] qt;
  logic signed [TW-1:0] t_fix;

  assign m_sat = (modulus > {1'b1, {WIDTH{1'b0}}}) ? {1'b1, {WIDTH{1'b0}}} : modulus;

  // q*t1 is built inside the divider as the quotient bits come out;
  // |q*t1| stays at or below m, so TW bits hold it
  mie_div #(.W(MW), .PW(TW)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .dividend(cmd.reduce ? v : r0),
    .divisor(cmd.reduce ? m : r1),
    .mcand(t1),
    .busy(sts.div_busy), .rem(rem), .prod(qt)
  );

  assign t_fix = t0 + $signed({1'b0, m});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m  <= m_sat;
      v  <= {1'b0, value};
      r0 <= m_sat;
      t0 <= '0;
      t1 <= TW'(1);
    end
    if (cmd.reduce_wr) r1 <= rem;
    if (cmd.update) begin
      r0 <= r1;
      r1 <= rem;
      t0 <= t1;
      t1 <= t0 - qt;
    end
    if (cmd.fix) begin
      if (r0 == MW'(1) && m >= MW'(2)) begin
        no_inverse <= 1'b0;
        inverse    <= t0[TW-1] ? t_fix[WIDTH-1:0] : t0[WIDTH-1:0];
      end else begin
        no_inverse <= 1'b1;
        inverse    <= '0;
      end
    end
  end

  assign sts.r1_zero = (r1 == '0);
  assign sts.bad_mod = (m < MW'(2));
endmodule

/* rtl/core/mie_ctrl.sv */
// ----------------------------------------------------------------------------
// mie_ctrl
// Sequencer for the Euclid rounds and the output handshake.
// ----------------------------------------------------------------------------
`include "modular_inverse_ext_euclid_unit_defines.svh"
module mie_ctrl
  import mie_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  mie_sts_t sts,
  output mie_cmd_t cmd
);
  mie_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (sts.bad_mod) state_next = ST_FIX;
        else begin
          cmd.div_start = 1'b1;
          cmd.reduce    = 1'b1;
          state_next    = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (!sts.div_busy) begin
          cmd.reduce_wr = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.r1_zero) state_next = ST_FIX;
        else begin
          cmd.div_start = 1'b1;
          state_next    = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!sts.div_busy) begin
          cmd.update = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_FIX: begin
        cmd.fix    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `MI_ASSERT(a_in_idle, clk, rst, in_ready |-> state == ST_IDLE, "accept outside idle")
  `MI_ASSERT(a_excl, clk, rst, !(in_ready && out_valid), "ready and valid together")
  `MI_ASSERT(a_fix, clk, rst, cmd.fix |=> out_valid, "result not shown after fix")
  `MI_ASSERT_NR(a_rst, clk, rst |=> state == ST_IDLE, "reset not to idle")
endmodule

/* tb/modular_inverse_ext_euclid_unit_tb.sv */
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid_unit_tb
// Checks the modular inverse unit against its own extended Euclid predictor.
// Directed values and moduli, then random items over several moduli, with
// random idling on both channels, a long receiver hold-off and a drain pause.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid_unit_tb;
  import mie_pkg::*;

  localparam int          WIDTH     = 40;
  localparam int          IDLE_PCT  = 18;
  localparam int          STALL_MAX = 20000;  // cycles with no handshake at all
  localparam logic [0:0]  REG_MODULUS = 1'b0; // register 0, byte address 0

  typedef logic [WIDTH-1:0] value_t;
  typedef logic [WIDTH:0]   modulus_t;
  typedef struct packed {
    logic [WIDTH-1:0] inverse;
    logic             no_inverse;
  } inverse_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [0:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  mie_if #(.payload_t(value_t))   in_ch ();
  mie_if #(.payload_t(inverse_t)) out_ch ();

  modular_inverse_ext_euclid_unit #(.WIDTH(WIDTH)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  modulus_t modulus_reg;      // our copy of the modulus register
  inverse_t pending_inverses[$];
  int       error_count;
  bit       steady;           // no idling on either side while set
  int       hold_off;         // receiver hold-off, in cycles
  int       quiet_cycles;

  // Extended Euclid on (m, v mod m), tracking the signed coefficient of v.
  function automatic inverse_t predict_inverse(value_t v, modulus_t m);
    longint unsigned mm, r0, r1, q, rn;
    longint          t0, t1, tn;
    inverse_t        res;
    res = '{inverse: '0, no_inverse: 1'b1};
    if (m < 2) return res;
    mm = (m > (modulus_t'(1) << WIDTH)) ? (64'd1 << WIDTH) : 64'(m);
    r0 = mm;
    r1 = 64'(v) % mm;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      q  = r0 / r1;
      rn = r0 - q * r1;
      tn = t0 - longint'(q) * t1;
      r0 = r1;
      r1 = rn;
      t0 = t1;
      t1 = tn;
    end
    if (r0 != 1) return res;
    if (t0 < 0) t0 = t0 + longint'(mm);
    res.inverse    = value_t'(longint'(t0) % longint'(mm));
    res.no_inverse = 1'b0;
    return res;
  endfunction

  // Receiver: random idling, or a counted hold-off.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_ch.ready <= 1'b0;
      hold_off     <= hold_off - 1;
    end else begin
      out_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Result checker: oldest expectation first.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_inverses.size() == 0) begin
        $error("unexpected result item: inverse %0h no_inverse %0b",
               out_ch.data.inverse, out_ch.data.no_inverse);
        error_count++;
      end else begin
        inverse_t exp_res;
        exp_res = pending_inverses.pop_front();
        if (out_ch.data.inverse !== exp_res.inverse) begin
          $error("inverse: expected %0h, got %0h", exp_res.inverse, out_ch.data.inverse);
          error_count++;
        end
        if (out_ch.data.no_inverse !== exp_res.no_inverse) begin
          $error("no_inverse: expected %0b, got %0b",
                 exp_res.no_inverse, out_ch.data.no_inverse);
          error_count++;
        end
      end
    end
  end

  // Watchdog: any handshake restarts the count.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one value, with a random gap first unless steady; returns at the accepting edge.
  task automatic send_value(value_t v);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data  <= v;
    do @(posedge clk); while (!in_ch.ready);
    pending_inverses.push_back(predict_inverse(v, modulus_reg));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_inverses.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);  // let the result handshake settle
  endtask

  // APB write: setup then access; block must be idle.
  task automatic write_modulus(modulus_t m);
    wait_drained();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_MODULUS;
    pwdata  <= 64'(m);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    modulus_reg = m;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic value_t rand_value();
    return value_t'({$urandom, $urandom});
  endfunction

  // Reset modulus 2^40: zero, one, two, three, all-ones and 2^39.
  task automatic test_reset_modulus();
    send_value('0);
    send_value(value_t'(1));
    send_value(value_t'(2));
    send_value(value_t'(3));
    send_value('1);
    send_value(value_t'(40'h80_0000_0000));
  endtask

  // Moduli at and beyond the legal edges, values below, at and above the modulus.
  task automatic test_modulus_extremes();
    write_modulus(modulus_t'(2));
    send_value(value_t'(1));
    send_value(value_t'(2));
    send_value('1);
    write_modulus(modulus_t'(97));
    send_value(value_t'(97));
    send_value(value_t'(98));
    send_value(value_t'(96));
    write_modulus('0);            // below two: never an inverse
    send_value(value_t'(1));
    write_modulus(modulus_t'(1));
    send_value(value_t'(3));
    write_modulus('1);            // saturates to 2^40
    send_value(value_t'(5));
    send_value('1);
    write_modulus(modulus_t'(40'hFF_FFFF_FFFF));
    send_value('1);
    send_value(value_t'(40'hFF_FFFF_FFFE));
    write_modulus(modulus_t'(1) << WIDTH);
  endtask

  // Receiver held off while the sender keeps offering: input must stall.
  task automatic test_backpressure();
    wait_drained();
    @(negedge clk);
    hold_off <= 3000;
    repeat (4) send_value(rand_value());
  endtask

  task automatic test_random(int n_items);
    for (int phase = 0; phase < 5; phase++) begin
      modulus_t m;
      case (phase)
        0: m = (modulus_t'(1) << WIDTH);
        1: m = modulus_t'({$urandom, $urandom}) | 1;
        2: m = modulus_t'($urandom_range(1000, 2));
        3: m = modulus_t'(rand_value()) | (modulus_t'(1) << (WIDTH - 1));
        default: m = modulus_t'($urandom_range(40, 0)) << $urandom_range(WIDTH - 6, 0);
      endcase
      if (m > (modulus_t'(1) << WIDTH)) m = modulus_t'(1) << WIDTH;
      write_modulus(m);
      steady = (phase == 2);
      for (int i = 0; i < n_items / 5; i++) begin
        if ($urandom_range(9) == 0) send_value(value_t'($urandom_range(3)));
        else send_value(rand_value());
      end
      steady = 1'b0;
    end
  endtask

  // Sender pauses until everything is back, then carries on.
  task automatic test_drain_pause();
    repeat (3) send_value(rand_value());
    wait_drained();
    repeat (3) send_value(rand_value());
  endtask

  initial begin
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    steady       = 1'b0;
    hold_off     = 0;
    error_count  = 0;
    modulus_reg  = modulus_t'(1) << WIDTH;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_modulus();
    test_modulus_extremes();
    test_backpressure();
    test_random(230);
    test_drain_pause();

    wait_drained();
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* modular_inverse_ext_euclid_unit.f */
+incdir+rtl/core
rtl/core/mie_pkg.sv
rtl/core/mie_if.sv
rtl/core/mie_div.sv
rtl/core/mie_datapath.sv
rtl/core/mie_ctrl.sv
rtl/core/modular_inverse_ext_euclid_unit.sv
tb/modular_inverse_ext_euclid_unit_tb.sv
